// File: design/bste_pkg.sv
// shared types, codes and defaults for the boruvka spanning tree engine
package bste_pkg;

	localparam int DEF_MAX_VERTICES = 1024;
	localparam int DEF_MAX_EDGES    = 4096;
	localparam int DEF_WEIGHT_BITS  = 32;

	localparam int RANK_W   = 4;
	localparam int RANK_MAX = 15;
	localparam int ROUND_W  = 5;
	localparam int ROUND_MAX = 31;
	localparam int SUM_W    = 48;
	localparam int NV_CFG_W = 11;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_RUN   = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_BAD_VERT  = 2'd2;
	localparam logic [1:0] ST_BAD_INDEX = 2'd3;

	typedef struct packed {
		logic [1:0]         command;
		logic [9:0]         endpoint_a;
		logic [9:0]         endpoint_b;
		logic signed [31:0] edge_weight_in;
		logic [9:0]         read_index;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [9:0]         tree_edge_count;
		logic signed [47:0] total_weight;
		logic [4:0]         round_count;
		logic [9:0]         tree_edge_a;
		logic [9:0]         tree_edge_b;
		logic signed [31:0] tree_edge_weight;
	} result_item_t;

	function automatic int addr_bits(input int depth);
		addr_bits = (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

// File: design/boruvka_spanning_tree_engine.sv
// top level: command decode, run sequencer and the four state memories
//
// usage
//   in channel (in_valid/in_ready/in_data): one command per transfer; load edge,
//   run spanning tree, read tree edge or clear graph
//   out channel (out_valid/out_ready/out_data): exactly one result per command,
//   in command order; the last run's count, weight sum and rounds are in every result
//   cfg_wr_en/cfg_wr_data: sets num_vertices (0 is taken as 1, large values clamp)
// flow
//   load and clear: result registered in the cycle after the transfer, one command
//   per cycle while the receiver takes each result; good read: tree store read, then
//   S_RDW loads the result and no command is taken before that; run: forest init of
//   all vertices, then per round the round control states, a check of each stored
//   edge plus its two root walks (only the check for a stale edge, the two offer
//   writes skipped when both ends share a root), and a check of each vertex plus, for
//   a kept edge, its root walks and the join states; S_DONE loads the result
// reset
//   control registers clear, num_vertices returns to MAX_VERTICES, no edges loaded,
//   no tree; memories keep their contents and are only read after being written
// stall
//   a result waits in the output register; the next command is taken only when none
//   waits or in the cycle it leaves, so nothing is lost when the receiver stalls
module boruvka_spanning_tree_engine #(
	parameter int MAX_VERTICES = bste_pkg::DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = bste_pkg::DEF_MAX_EDGES,
	parameter int WEIGHT_BITS  = bste_pkg::DEF_WEIGHT_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  bste_pkg::cmd_item_t              in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output bste_pkg::result_item_t           out_data,
	input  logic                             cfg_wr_en,
	input  logic [bste_pkg::NV_CFG_W-1:0]    cfg_wr_data
);

	localparam int VW  = bste_pkg::addr_bits(MAX_VERTICES);
	localparam int NVW = VW + 1;
	localparam int EW  = bste_pkg::addr_bits(MAX_EDGES);
	localparam int TD  = (MAX_VERTICES > 1) ? MAX_VERTICES - 1 : 1;
	localparam int TAW = bste_pkg::addr_bits(TD);
	localparam int WB  = WEIGHT_BITS;
	localparam int RW  = bste_pkg::RANK_W;
	localparam int EDGE_W  = 2 * VW + WB;
	localparam int CHEAP_W = 1 + 2 * VW + WB;
	localparam int PAR_W   = RW + VW;

	// sequencer states
	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_RDW    = 5'd1;
	localparam logic [4:0] S_INIT   = 5'd2;
	localparam logic [4:0] S_RSTART = 5'd3;
	localparam logic [4:0] S_SE_RD  = 5'd4;
	localparam logic [4:0] S_SE_CHK = 5'd5;
	localparam logic [4:0] S_WALK   = 5'd6;
	localparam logic [4:0] S_OFA_RD = 5'd7;
	localparam logic [4:0] S_OFA_WR = 5'd8;
	localparam logic [4:0] S_OFB_WR = 5'd9;
	localparam logic [4:0] S_MG_RD  = 5'd10;
	localparam logic [4:0] S_MG_CHK = 5'd11;
	localparam logic [4:0] S_JOIN   = 5'd12;
	localparam logic [4:0] S_JOIN2  = 5'd13;
	localparam logic [4:0] S_REND   = 5'd14;
	localparam logic [4:0] S_DONE   = 5'd15;

	logic [4:0] state_q, wk_ret_q;

	// configuration and run status
	logic [NVW-1:0]                 nv_q;
	logic [EW:0]                    loaded_q;
	logic [VW-1:0]                  tc_q;
	logic signed [bste_pkg::SUM_W-1:0] sum_q;
	logic [bste_pkg::ROUND_W-1:0]   rounds_q;
	logic [NVW-1:0]                 trees_q;
	logic                           joined_q;

	// run working registers
	logic [EW:0]          e_q;
	logic [NVW-1:0]       c_q;
	logic [VW-1:0]        va_q, vb_q, walk_r_q, ra_q;
	logic [RW-1:0]        rka_q;
	logic signed [WB-1:0] w_q;
	logic                 wk_second_q;

	// result register
	logic                 out_valid_q;
	logic [1:0]           res_status_q;
	logic [9:0]           res_a_q, res_b_q;
	logic signed [31:0]   res_w_q;

	// memory ports
	logic              em_we;
	logic [EW-1:0]     em_waddr, em_raddr;
	logic [EDGE_W-1:0] em_wdata, em_rdata;
	logic               cm_we;
	logic [VW-1:0]      cm_waddr, cm_raddr;
	logic [CHEAP_W-1:0] cm_wdata, cm_rdata;
	logic             pm_we;
	logic [VW-1:0]    pm_waddr, pm_raddr;
	logic [PAR_W-1:0] pm_wdata, pm_rdata;
	logic              tm_we;
	logic [TAW-1:0]    tm_waddr, tm_raddr;
	logic [EDGE_W-1:0] tm_wdata, tm_rdata;

	// unpacked memory words
	logic [VW-1:0]        ed_a, ed_b;
	logic signed [WB-1:0] ed_w;
	logic                 cd_valid;
	logic [VW-1:0]        cd_a, cd_b;
	logic signed [WB-1:0] cd_w;
	logic [RW-1:0]        pd_rank;
	logic [VW-1:0]        pd_parent;
	logic [VW-1:0]        td_a, td_b;
	logic signed [WB-1:0] td_w;

	assign {ed_a, ed_b, ed_w}          = em_rdata;
	assign {cd_valid, cd_a, cd_b, cd_w} = cm_rdata;
	assign {pd_rank, pd_parent}        = pm_rdata;
	assign {td_a, td_b, td_w}          = tm_rdata;

	bste_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_mem (
		.clk(clk), .we(em_we), .waddr(em_waddr), .wdata(em_wdata),
		.raddr(em_raddr), .rdata(em_rdata)
	);
	bste_ram #(.WIDTH(CHEAP_W), .DEPTH(MAX_VERTICES)) u_cheap_mem (
		.clk(clk), .we(cm_we), .waddr(cm_waddr), .wdata(cm_wdata),
		.raddr(cm_raddr), .rdata(cm_rdata)
	);
	bste_ram #(.WIDTH(PAR_W), .DEPTH(MAX_VERTICES)) u_parent_mem (
		.clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
		.raddr(pm_raddr), .rdata(pm_rdata)
	);
	bste_ram #(.WIDTH(EDGE_W), .DEPTH(TD)) u_tree_mem (
		.clk(clk), .we(tm_we), .waddr(tm_waddr), .wdata(tm_wdata),
		.raddr(tm_raddr), .rdata(tm_rdata)
	);

	logic in_xfer;
	logic vert_bad, store_full, idx_bad, cheaper;
	logic res_set;
	logic signed [WB-1:0] in_w;
	logic [NVW-1:0] nv_cfg;

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign in_xfer  = in_valid && in_ready;
	assign in_w     = WB'(in_data.edge_weight_in);

	assign vert_bad   = (32'(in_data.endpoint_a) >= 32'(nv_q))
		|| (32'(in_data.endpoint_b) >= 32'(nv_q));
	assign store_full = 32'(loaded_q) >= 32'(MAX_EDGES);
	assign idx_bad    = 32'(in_data.read_index) >= 32'(tc_q);
	// offer test: empty slot or strictly cheaper edge
	assign cheaper    = !cd_valid || (cd_w > w_q);

	// a result is loaded for every command except a run start and a good read,
	// which finish later in S_DONE and S_RDW
	assign res_set = (in_xfer && (in_data.command != bste_pkg::CMD_RUN)
		&& !((in_data.command == bste_pkg::CMD_READ) && !idx_bad))
		|| (state_q == S_RDW) || (state_q == S_DONE);

	always_comb begin
		if (cfg_wr_data == '0) begin
			nv_cfg = NVW'(1);
		end else if (32'(cfg_wr_data) > 32'(MAX_VERTICES)) begin
			nv_cfg = NVW'(MAX_VERTICES);
		end else begin
			nv_cfg = NVW'(cfg_wr_data);
		end
	end

	// memory port steering per state
	always_comb begin
		em_we    = 1'b0;
		em_waddr = loaded_q[EW-1:0];
		em_wdata = {VW'(in_data.endpoint_a), VW'(in_data.endpoint_b), in_w};
		em_raddr = e_q[EW-1:0];
		cm_we    = 1'b0;
		cm_waddr = c_q[VW-1:0];
		cm_wdata = '0;
		cm_raddr = c_q[VW-1:0];
		pm_we    = 1'b0;
		pm_waddr = c_q[VW-1:0];
		pm_wdata = {RW'(0), c_q[VW-1:0]};
		pm_raddr = walk_r_q;
		tm_we    = 1'b0;
		tm_waddr = TAW'(tc_q);
		tm_wdata = {va_q, vb_q, w_q};
		tm_raddr = TAW'(in_data.read_index);
		case (state_q)
			S_IDLE: begin
				em_we = in_xfer && (in_data.command == bste_pkg::CMD_LOAD)
					&& !vert_bad && !store_full;
			end
			S_INIT: begin
				// fresh singleton trees and empty cheapest slots
				pm_we = 1'b1;
				cm_we = 1'b1;
			end
			S_SE_CHK: begin
				pm_raddr = ed_a;
			end
			S_WALK: begin
				if (pd_parent != walk_r_q) begin
					pm_raddr = pd_parent;
				end else if (!wk_second_q) begin
					pm_raddr = vb_q;
				end else begin
					// keep the second root's entry for the join
					pm_raddr = walk_r_q;
				end
			end
			S_OFA_RD: begin
				cm_raddr = ra_q;
			end
			S_OFA_WR: begin
				cm_we    = cheaper;
				cm_waddr = ra_q;
				cm_wdata = {1'b1, va_q, vb_q, w_q};
				cm_raddr = walk_r_q;
			end
			S_OFB_WR: begin
				cm_we    = cheaper;
				cm_waddr = walk_r_q;
				cm_wdata = {1'b1, vb_q, va_q, w_q};
			end
			S_MG_CHK: begin
				// consume the slot so the next round starts empty
				cm_we    = 1'b1;
				pm_raddr = cd_a;
			end
			S_JOIN: begin
				tm_we = (ra_q != walk_r_q) && (32'(tc_q) < 32'(MAX_VERTICES - 1));
				pm_we = tm_we;
				if (rka_q < pd_rank) begin
					pm_waddr = ra_q;
					pm_wdata = {rka_q, walk_r_q};
				end else begin
					pm_waddr = walk_r_q;
					pm_wdata = {pd_rank, ra_q};
				end
			end
			S_JOIN2: begin
				pm_we    = 1'b1;
				pm_waddr = ra_q;
				pm_wdata = {rka_q + RW'(1), ra_q};
			end
			default: begin
			end
		endcase
	end

	// S_JOIN holds rb in walk_r_q and rank of rb on the parent read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			wk_ret_q     <= S_IDLE;
			nv_q         <= NVW'(MAX_VERTICES);
			loaded_q     <= '0;
			tc_q         <= '0;
			sum_q        <= '0;
			rounds_q     <= '0;
			trees_q      <= '0;
			joined_q     <= 1'b0;
			e_q          <= '0;
			c_q          <= '0;
			va_q         <= '0;
			vb_q         <= '0;
			walk_r_q     <= '0;
			ra_q         <= '0;
			rka_q        <= '0;
			w_q          <= '0;
			wk_second_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			res_status_q <= bste_pkg::ST_OK;
			res_a_q      <= '0;
			res_b_q      <= '0;
			res_w_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				nv_q <= nv_cfg;
			end
			if (res_set) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						res_a_q <= '0;
						res_b_q <= '0;
						res_w_q <= '0;
						case (in_data.command)
							bste_pkg::CMD_LOAD: begin
								if (vert_bad) begin
									res_status_q <= bste_pkg::ST_BAD_VERT;
								end else if (store_full) begin
									res_status_q <= bste_pkg::ST_FULL;
								end else begin
									res_status_q <= bste_pkg::ST_OK;
									loaded_q     <= loaded_q + (EW+1)'(1);
								end
							end
							bste_pkg::CMD_RUN: begin
								res_status_q <= bste_pkg::ST_OK;
								c_q          <= '0;
								tc_q         <= '0;
								sum_q        <= '0;
								rounds_q     <= '0;
								trees_q      <= nv_q;
								state_q      <= S_INIT;
							end
							bste_pkg::CMD_READ: begin
								if (idx_bad) begin
									res_status_q <= bste_pkg::ST_BAD_INDEX;
								end else begin
									res_status_q <= bste_pkg::ST_OK;
									state_q      <= S_RDW;
								end
							end
							default: begin
								res_status_q <= bste_pkg::ST_OK;
								loaded_q     <= '0;
							end
						endcase
					end
				end
				S_RDW: begin
					res_a_q <= 10'(td_a);
					res_b_q <= 10'(td_b);
					res_w_q <= 32'(td_w);
					state_q <= S_IDLE;
				end
				S_INIT: begin
					if (c_q == nv_q - NVW'(1)) begin
						state_q <= S_RSTART;
					end
					c_q <= c_q + NVW'(1);
				end
				S_RSTART: begin
					e_q      <= '0;
					joined_q <= 1'b0;
					state_q  <= (trees_q > NVW'(1)) ? S_SE_RD : S_DONE;
				end
				S_SE_RD: begin
					if (loaded_q == e_q) begin
						c_q     <= '0;
						state_q <= S_MG_RD;
					end else begin
						state_q <= S_SE_CHK;
					end
				end
				S_SE_CHK: begin
					if ((32'(ed_a) >= 32'(nv_q)) || (32'(ed_b) >= 32'(nv_q))) begin
						// stale edge from a larger vertex count
						e_q     <= e_q + (EW+1)'(1);
						state_q <= S_SE_RD;
					end else begin
						va_q        <= ed_a;
						vb_q        <= ed_b;
						w_q         <= ed_w;
						walk_r_q    <= ed_a;
						wk_second_q <= 1'b0;
						wk_ret_q    <= S_OFA_RD;
						state_q     <= S_WALK;
					end
				end
				S_WALK: begin
					// one parent hop per cycle until a self link marks the root
					if (pd_parent != walk_r_q) begin
						walk_r_q <= pd_parent;
					end else if (!wk_second_q) begin
						ra_q        <= walk_r_q;
						rka_q       <= pd_rank;
						walk_r_q    <= vb_q;
						wk_second_q <= 1'b1;
					end else begin
						state_q <= wk_ret_q;
					end
				end
				S_OFA_RD: begin
					if (ra_q == walk_r_q) begin
						e_q     <= e_q + (EW+1)'(1);
						state_q <= S_SE_RD;
					end else begin
						state_q <= S_OFA_WR;
					end
				end
				S_OFA_WR: begin
					state_q <= S_OFB_WR;
				end
				S_OFB_WR: begin
					e_q     <= e_q + (EW+1)'(1);
					state_q <= S_SE_RD;
				end
				S_MG_RD: begin
					state_q <= (c_q == nv_q) ? S_REND : S_MG_CHK;
				end
				S_MG_CHK: begin
					if (!cd_valid) begin
						c_q     <= c_q + NVW'(1);
						state_q <= S_MG_RD;
					end else begin
						va_q        <= cd_a;
						vb_q        <= cd_b;
						w_q         <= cd_w;
						walk_r_q    <= cd_a;
						wk_second_q <= 1'b0;
						wk_ret_q    <= S_JOIN;
						state_q     <= S_WALK;
					end
				end
				S_JOIN: begin
					// equal ranks: the surviving root gains a rank, up to RANK_MAX
					if (tm_we && (rka_q == pd_rank)
							&& (32'(rka_q) < bste_pkg::RANK_MAX)) begin
						state_q <= S_JOIN2;
					end else begin
						c_q     <= c_q + NVW'(1);
						state_q <= S_MG_RD;
					end
					if (tm_we) begin
						tc_q     <= tc_q + VW'(1);
						sum_q    <= sum_q + bste_pkg::SUM_W'(w_q);
						trees_q  <= trees_q - NVW'(1);
						joined_q <= 1'b1;
					end
				end
				S_JOIN2: begin
					c_q     <= c_q + NVW'(1);
					state_q <= S_MG_RD;
				end
				S_REND: begin
					if (32'(rounds_q) < bste_pkg::ROUND_MAX) begin
						rounds_q <= rounds_q + bste_pkg::ROUND_W'(1);
					end
					state_q <= joined_q ? S_RSTART : S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		out_data.status           = res_status_q;
		out_data.tree_edge_count  = 10'(tc_q);
		out_data.total_weight     = sum_q;
		out_data.round_count      = rounds_q;
		out_data.tree_edge_a      = res_a_q;
		out_data.tree_edge_b      = res_b_q;
		out_data.tree_edge_weight = res_w_q;
	end

`ifndef SYNTHESIS
	a_loaded_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(loaded_q) <= 32'(MAX_EDGES))
		else $error("edge count beyond store depth");
	a_tree_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(tc_q) <= 32'(MAX_VERTICES - 1))
		else $error("tree edge count beyond vertex count");
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (32'(walk_r_q) < 32'(nv_q)))
		else $error("root walk left the active vertex range");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> ((state_q == S_IDLE) && (!out_valid_q || out_ready)))
		else $error("command taken while busy or result pending");
	a_run_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |=> (out_valid && (out_data.status == bste_pkg::ST_OK)))
		else $error("run finished without an ok result");
`endif

endmodule

// File: design/bste_ram.sv
// single write port, single registered read port memory
module bste_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [bste_pkg::addr_bits(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [bste_pkg::addr_bits(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: tb/boruvka_spanning_tree_engine_tb.sv
// testbench for the boruvka spanning tree engine: directed and random command streams
`timescale 1ns / 1ps

module boruvka_spanning_tree_engine_tb;

	localparam int NV_MAX      = bste_pkg::DEF_MAX_VERTICES;
	localparam int EDGE_MAX    = bste_pkg::DEF_MAX_EDGES;
	localparam int CYCLE_LIMIT = 20000000;
	localparam int DRAIN_WAIT  = 20;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	bste_pkg::cmd_item_t      in_data;
	logic                     out_valid;
	logic                     out_ready;
	bste_pkg::result_item_t   out_data;
	logic                     cfg_wr_en;
	logic [bste_pkg::NV_CFG_W-1:0] cfg_wr_data;

	boruvka_spanning_tree_engine u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// shadow of the engine: graph, forest and last tree
	int                 vert_limit;
	logic [9:0]         graph_a [EDGE_MAX];
	logic [9:0]         graph_b [EDGE_MAX];
	logic signed [31:0] graph_w [EDGE_MAX];
	int                 edges_held;
	int                 forest_up [NV_MAX];
	int                 forest_rank [NV_MAX];
	bit                 best_ok [NV_MAX];
	logic [9:0]         best_a [NV_MAX];
	logic [9:0]         best_b [NV_MAX];
	logic signed [31:0] best_w [NV_MAX];
	logic [9:0]         span_a [NV_MAX];
	logic [9:0]         span_b [NV_MAX];
	logic signed [31:0] span_w [NV_MAX];
	int                 span_edges;
	logic [47:0]        span_weight;
	int                 span_rounds;

	bste_pkg::result_item_t pending_results [$];
	int  mismatches;
	int  sent_count;
	bit  stall_on;
	longint cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int find_root(int v);
		int r;
		r = v;
		for (int i = 0; i < NV_MAX; i++) begin
			if (forest_up[r] == r) break;
			r = forest_up[r];
		end
		return r;
	endfunction

	// keep the strictly cheaper edge; first offer wins a tie
	function automatic void offer_edge(int comp, logic [9:0] from, logic [9:0] to,
			logic signed [31:0] w);
		if (!best_ok[comp] || best_w[comp] > w) begin
			best_ok[comp] = 1'b1;
			best_a[comp] = from;
			best_b[comp] = to;
			best_w[comp] = w;
		end
	endfunction

	function automatic void build_tree();
		int trees, joined, ra, rb;
		trees = vert_limit;
		for (int v = 0; v < vert_limit; v++) begin
			forest_up[v] = v;
			forest_rank[v] = 0;
		end
		span_edges = 0;
		span_weight = '0;
		span_rounds = 0;
		while (trees > 1) begin
			joined = 0;
			for (int c = 0; c < NV_MAX; c++) best_ok[c] = 1'b0;
			// scan edges in load order, skipping stale and internal ones
			for (int e = 0; e < edges_held; e++) begin
				if (graph_a[e] >= vert_limit || graph_b[e] >= vert_limit) continue;
				ra = find_root(graph_a[e]);
				rb = find_root(graph_b[e]);
				if (ra == rb) continue;
				offer_edge(ra, graph_a[e], graph_b[e], graph_w[e]);
				offer_edge(rb, graph_b[e], graph_a[e], graph_w[e]);
			end
			// merge in ascending component order
			for (int c = 0; c < vert_limit; c++) begin
				if (!best_ok[c]) continue;
				ra = find_root(best_a[c]);
				rb = find_root(best_b[c]);
				if (ra == rb || span_edges >= NV_MAX - 1) continue;
				span_a[span_edges] = best_a[c];
				span_b[span_edges] = best_b[c];
				span_w[span_edges] = best_w[c];
				span_edges++;
				span_weight = span_weight + {{16{best_w[c][31]}}, best_w[c]};
				if (forest_rank[ra] < forest_rank[rb]) forest_up[ra] = rb;
				else if (forest_rank[ra] > forest_rank[rb]) forest_up[rb] = ra;
				else begin
					forest_up[rb] = ra;
					if (forest_rank[ra] < bste_pkg::RANK_MAX) forest_rank[ra]++;
				end
				trees--;
				joined++;
			end
			if (span_rounds < bste_pkg::ROUND_MAX) span_rounds++;
			if (joined == 0) break;
		end
	endfunction

	function automatic bste_pkg::result_item_t apply_command(bste_pkg::cmd_item_t c);
		bste_pkg::result_item_t r;
		r = '0;
		case (c.command)
			bste_pkg::CMD_LOAD: begin
				if (c.endpoint_a >= vert_limit || c.endpoint_b >= vert_limit)
					r.status = bste_pkg::ST_BAD_VERT;
				else if (edges_held >= EDGE_MAX)
					r.status = bste_pkg::ST_FULL;
				else begin
					graph_a[edges_held] = c.endpoint_a;
					graph_b[edges_held] = c.endpoint_b;
					graph_w[edges_held] = c.edge_weight_in;
					edges_held++;
				end
			end
			bste_pkg::CMD_RUN: build_tree();
			bste_pkg::CMD_READ: begin
				if (c.read_index >= span_edges) r.status = bste_pkg::ST_BAD_INDEX;
				else begin
					r.tree_edge_a = span_a[c.read_index];
					r.tree_edge_b = span_b[c.read_index];
					r.tree_edge_weight = span_w[c.read_index];
				end
			end
			default: edges_held = 0;
		endcase
		r.tree_edge_count = span_edges[9:0];
		r.total_weight = span_weight;
		r.round_count = span_rounds[4:0];
		return r;
	endfunction

	// one command transfer; valid stays high after acceptance until the next call decides
	task automatic push_command(bste_pkg::cmd_item_t c);
		while (stall_on && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= c;
		pending_results = {pending_results, apply_command(c)};
		sent_count++;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_vertices(int v);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v[bste_pkg::NV_CFG_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		if (v == 0) vert_limit = 1;
		else if (v > NV_MAX) vert_limit = NV_MAX;
		else vert_limit = v;
	endtask

	task automatic send_op(logic [1:0] op, int a, int b, int w, int idx);
		bste_pkg::cmd_item_t c;
		c.command = op;
		c.endpoint_a = a[9:0];
		c.endpoint_b = b[9:0];
		c.edge_weight_in = w;
		c.read_index = idx[9:0];
		push_command(c);
	endtask

	task automatic read_all_tree(int extra);
		for (int i = 0; i < span_edges; i++) send_op(bste_pkg::CMD_READ, 0, 0, 0, i);
		for (int i = 0; i < extra; i++)
			send_op(bste_pkg::CMD_READ, 0, 0, 0, $urandom_range(1023));
	endtask

	// empty store, extremes of weights and ids, self loop, clamped settings
	task automatic test_directed();
		send_op(bste_pkg::CMD_READ, 0, 0, 0, 0);
		send_op(bste_pkg::CMD_RUN, 0, 0, 0, 0);
		send_op(bste_pkg::CMD_LOAD, 1023, 0, 32'h8000_0000, 0);
		send_op(bste_pkg::CMD_LOAD, 0, 1023, 32'h7fff_ffff, 0);
		send_op(bste_pkg::CMD_LOAD, 5, 5, 32'h8000_0000, 0);
		send_op(bste_pkg::CMD_LOAD, 1023, 512, -7, 0);
		send_op(bste_pkg::CMD_RUN, 0, 0, 0, 0);
		send_op(bste_pkg::CMD_READ, 0, 0, 0, 0);
		send_op(bste_pkg::CMD_READ, 0, 0, 0, 1);
		send_op(bste_pkg::CMD_READ, 0, 0, 0, 2);
		send_op(bste_pkg::CMD_READ, 0, 0, 0, 1023);
		send_op(bste_pkg::CMD_CLEAR, 1023, 1023, -1, 1023);
		send_op(bste_pkg::CMD_READ, 0, 0, 0, 1);
		set_vertices(0);
		send_op(bste_pkg::CMD_LOAD, 0, 0, 3, 0);
		send_op(bste_pkg::CMD_LOAD, 0, 1, 3, 0);
		send_op(bste_pkg::CMD_RUN, 0, 0, 0, 0);
		send_op(bste_pkg::CMD_READ, 0, 0, 0, 0);
		set_vertices(2047);
		send_op(bste_pkg::CMD_CLEAR, 0, 0, 0, 0);
		set_vertices(1);
		send_op(bste_pkg::CMD_LOAD, 1, 0, 0, 0);
		send_op(bste_pkg::CMD_CLEAR, 0, 0, 0, 0);
	endtask

	// equal weights everywhere: the first scanned edge must win
	task automatic test_ties();
		set_vertices(6);
		send_op(bste_pkg::CMD_CLEAR, 0, 0, 0, 0);
		for (int i = 0; i < 6; i++) send_op(bste_pkg::CMD_LOAD, i, (i + 1) % 6, 4, 0);
		send_op(bste_pkg::CMD_LOAD, 0, 3, 4, 0);
		send_op(bste_pkg::CMD_LOAD, 2, 5, 4, 0);
		send_op(bste_pkg::CMD_RUN, 0, 0, 0, 0);
		read_all_tree(1);
	endtask

	// shrink the vertex range after loading so some edges go stale
	task automatic test_stale_edges();
		set_vertices(16);
		send_op(bste_pkg::CMD_CLEAR, 0, 0, 0, 0);
		for (int i = 0; i < 20; i++)
			send_op(bste_pkg::CMD_LOAD, $urandom_range(15), $urandom_range(15),
				$urandom_range(50), 0);
		set_vertices(8);
		send_op(bste_pkg::CMD_RUN, 0, 0, 0, 0);
		read_all_tree(2);
	endtask

	// loads with an id at or above the vertex range are refused
	task automatic test_bad_vertex();
		set_vertices(1024);
		send_op(bste_pkg::CMD_CLEAR, 0, 0, 0, 0);
		send_op(bste_pkg::CMD_LOAD, 1, 2, 9, 0);
		set_vertices(100);
		send_op(bste_pkg::CMD_LOAD, 1000, 2, 9, 0);
		send_op(bste_pkg::CMD_LOAD, 2, 100, 9, 0);
		send_op(bste_pkg::CMD_LOAD, 3, 2, 9, 0);
		send_op(bste_pkg::CMD_CLEAR, 0, 0, 0, 0);
	endtask

	// one random graph: mostly well-formed loads, then run and read back
	task automatic graph_round(int nv, int n_edges, bit quiet);
		int w;
		set_vertices(nv);
		stall_on = !quiet;
		send_op(bste_pkg::CMD_CLEAR, 0, 0, 0, 0);
		for (int i = 0; i < n_edges; i++) begin
			w = ($urandom_range(3) == 0) ? $urandom : $urandom_range(20) - 10;
			if ($urandom_range(15) == 0)
				send_op(bste_pkg::CMD_LOAD, $urandom_range(1023), $urandom_range(1023), w, 0);
			else
				send_op(bste_pkg::CMD_LOAD, $urandom_range(vert_limit - 1),
					$urandom_range(vert_limit - 1), w, $urandom_range(1023));
		end
		if ($urandom_range(7) == 0)
			send_op($urandom_range(3), $urandom_range(1023), $urandom_range(1023),
				$urandom, $urandom_range(1023));
		send_op(bste_pkg::CMD_RUN, $urandom_range(1023), $urandom_range(1023), $urandom, 0);
		read_all_tree($urandom_range(2));
		stall_on = 1'b1;
	endtask

	task automatic test_random_graphs();
		int nv;
		int phase;
		phase = 0;
		while (sent_count < 1500) begin
			case ($urandom_range(9))
				0: nv = $urandom_range(1, 3);
				1: nv = $urandom_range(64, 200);
				default: nv = $urandom_range(4, 32);
			endcase
			graph_round(nv, $urandom_range(0, 2 * nv + 4), phase == 5);
			phase++;
		end
		graph_round(1024, 40, 1'b0);
	endtask

	// receiver side: random stall and compare with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		bste_pkg::result_item_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %p", out_data);
				end else begin
					want = pending_results.pop_front();
					if (out_data.status !== want.status ||
							out_data.tree_edge_count !== want.tree_edge_count ||
							out_data.total_weight !== want.total_weight ||
							out_data.round_count !== want.round_count ||
							out_data.tree_edge_a !== want.tree_edge_a ||
							out_data.tree_edge_b !== want.tree_edge_b ||
							out_data.tree_edge_weight !== want.tree_edge_weight) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p actual %p", want, out_data);
					end
				end
			end
			out_ready <= !stall_on || ($urandom_range(99) >= 26);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		cycles = 0;
		mismatches = 0;
		sent_count = 0;
		stall_on = 1'b1;
		vert_limit = NV_MAX;
		edges_held = 0;
		span_edges = 0;
		span_weight = '0;
		span_rounds = 0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_ties();
		test_stale_edges();
		test_bad_vertex();
		test_random_graphs();
		drain_results();
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
